>>> sv/thbp_pkg.sv
package thbp_pkg;

   // Record framing limits.
   localparam logic [15:0] HEADER_BYTES = 16'd3;
   localparam logic [15:0] MIN_PADDING  = 16'd16;
   localparam logic [15:0] MAX_RECORD   = 16'h4000;

   typedef enum logic [2:0] {
      PH_TYPE    = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_PADDING = 3'd4,
      PH_DISCARD = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      KIND_TYPE    = 3'd0,
      KIND_LENGTH  = 3'd1,
      KIND_PAYLOAD = 3'd2,
      KIND_PADDING = 3'd3,
      KIND_DISCARD = 3'd4
   } byte_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_flag;
   } req_item_type;

   typedef struct packed {
      byte_kind_type byte_kind;
      logic [7:0]    byte_value;
      logic [7:0]    message_type;
      logic [15:0]   payload_size;
      logic          length_error;
      logic          message_done;
   } rsp_item_type;

endpackage

>>> sv/thbp_ifs.sv
interface thbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_flag;

   modport source (output valid, output data_byte, output start_flag, input ready);
   modport sink (input valid, input data_byte, input start_flag, output ready);
endinterface

interface thbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_kind;
   logic [7:0]  byte_value;
   logic [7:0]  message_type;
   logic [15:0] payload_size;
   logic        length_error;
   logic        message_done;

   modport source (output valid, output byte_kind, output byte_value, output message_type,
                   output payload_size, output length_error, output message_done,
                   input ready);
   modport sink (input valid, input byte_kind, input byte_value, input message_type,
                 input payload_size, input length_error, input message_done,
                 output ready);
endinterface

>>> sv/tls_heartbeat_message_parser_core.sv
// Heartbeat record parser: takes the plaintext of one heartbeat record one byte per
// request and returns one classified byte per request, in order. The first byte is
// the message type and the next two are the big-endian payload length; the length is
// checked against csr_wr_data as last written (the record length), which must leave
// at least 16 bytes of padding and must not exceed 16384. A failed check sets
// length_error on the low length byte and later bytes come back as discarded until a
// request with start_flag set, which always restarts parsing at the type byte. The
// last padding byte sets message_done. Throughput is one byte per cycle while the
// response side is not stalled; a request passes through the input register and
// then the response register, around a single compare-and-count step. The record
// length must be written only while no request is in flight.
module tls_heartbeat_message_parser_core (
   input  logic        clock,
   input  logic        reset,
   thbp_req_if.sink    req_chan,
   thbp_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import thbp_pkg::*;

   // Hand-off between the input register and the parsing stage.
   logic         stage_valid;
   logic         stage_take;
   req_item_type stage_item;

   // The input register holds one request; it refills while its request moves on.
   thbp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .stage_valid (stage_valid),
      .stage_item  (stage_item),
      .stage_take  (stage_take)
   );

   // The parsing stage holds the message state and the response register, so a
   // stalled response never blocks the request side for more than one entry.
   thbp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stage_valid (stage_valid),
      .stage_item  (stage_item),
      .stage_take  (stage_take),
      .rsp_chan    (rsp_chan)
   );

endmodule

>>> sv/thbp_in_stage.sv
module thbp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   thbp_req_if.sink              req_chan,
   output logic                  stage_valid,
   output thbp_pkg::req_item_type stage_item,
   input  logic                  stage_take
);
   import thbp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   // The stage refills in the same cycle that it hands its request on.
   assign req_chan.ready = !valid_ff || stage_take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (stage_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.data_byte  <= req_chan.data_byte;
         item_ff.start_flag <= req_chan.start_flag;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

>>> sv/thbp_parse.sv
module thbp_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   input  logic                   stage_valid,
   input  thbp_pkg::req_item_type stage_item,
   output logic                   stage_take,
   thbp_rsp_if.source             rsp_chan
);
   import thbp_pkg::*;

   logic [15:0]  record_length_ff;

   phase_type    phase_ff, phase_in;
   logic [7:0]   type_held_ff, type_held_in;
   logic [7:0]   length_high_ff, length_high_in;
   logic [15:0]  payload_held_ff, payload_held_in;
   logic [15:0]  bytes_left_ff, bytes_left_in;
   logic [15:0]  padding_held_ff, padding_held_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic         advance;
   phase_type    phase_now;
   logic [15:0]  payload_new;
   logic [16:0]  min_record;
   logic         length_bad;
   logic [15:0]  padding_new;
   logic [15:0]  bytes_dec;
   logic         zero_left;

   assign advance    = stage_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign stage_take = advance;

   // A start flag forces the byte to be taken as the type byte.
   assign phase_now = stage_item.start_flag ? PH_TYPE : phase_ff;

   // Length check: payload + header + minimum padding must fit, and the record
   // itself must not exceed the protocol maximum.
   assign payload_new = {length_high_ff, stage_item.data_byte};
   assign min_record  = {1'b0, payload_new} + {1'b0, HEADER_BYTES} + {1'b0, MIN_PADDING};
   assign length_bad  = (min_record > {1'b0, record_length_ff}) ||
                        (record_length_ff > MAX_RECORD);
   assign padding_new = record_length_ff - payload_new - HEADER_BYTES;
   assign bytes_dec   = bytes_left_ff - 16'd1;
   assign zero_left   = (bytes_dec == 16'd0);

   // Next state.
   always_comb begin
      phase_in        = phase_ff;
      type_held_in    = type_held_ff;
      length_high_in  = length_high_ff;
      payload_held_in = payload_held_ff;
      bytes_left_in   = bytes_left_ff;
      padding_held_in = padding_held_ff;
      if (advance) begin
         phase_in = phase_now;
         unique case (phase_now)
            PH_TYPE: begin
               type_held_in    = stage_item.data_byte;
               payload_held_in = 16'd0;
               phase_in        = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_high_in = stage_item.data_byte;
               phase_in       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               payload_held_in = payload_new;
               if (length_bad) begin
                  phase_in = PH_DISCARD;
               end else begin
                  padding_held_in = padding_new;
                  if (payload_new != 16'd0) begin
                     bytes_left_in = payload_new;
                     phase_in      = PH_PAYLOAD;
                  end else begin
                     bytes_left_in = padding_new;
                     phase_in      = PH_PADDING;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (zero_left) begin
                  bytes_left_in = padding_held_ff;
                  phase_in      = PH_PADDING;
               end else begin
                  bytes_left_in = bytes_dec;
               end
            end
            PH_PADDING: begin
               bytes_left_in = bytes_dec;
               if (zero_left) begin
                  phase_in = PH_DISCARD;
               end
            end
            default: begin
               phase_in = phase_now;
            end
         endcase
      end
   end

   // Result for the byte in the input register.
   always_comb begin
      rsp_item_in.byte_value   = stage_item.data_byte;
      rsp_item_in.message_type = type_held_in;
      rsp_item_in.payload_size = payload_held_in;
      rsp_item_in.length_error = 1'b0;
      rsp_item_in.message_done = 1'b0;
      unique case (phase_now)
         PH_TYPE: begin
            rsp_item_in.byte_kind = KIND_TYPE;
         end
         PH_LEN_HI: begin
            rsp_item_in.byte_kind = KIND_LENGTH;
         end
         PH_LEN_LO: begin
            rsp_item_in.byte_kind    = KIND_LENGTH;
            rsp_item_in.length_error = length_bad;
         end
         PH_PAYLOAD: begin
            rsp_item_in.byte_kind = KIND_PAYLOAD;
         end
         PH_PADDING: begin
            rsp_item_in.byte_kind    = KIND_PADDING;
            rsp_item_in.message_done = zero_left;
         end
         default: begin
            rsp_item_in.byte_kind = KIND_DISCARD;
         end
      endcase
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         record_length_ff <= 16'd0;
         phase_ff         <= PH_TYPE;
         type_held_ff     <= 8'd0;
         length_high_ff   <= 8'd0;
         payload_held_ff  <= 16'd0;
         bytes_left_ff    <= 16'd0;
         padding_held_ff  <= 16'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            record_length_ff <= csr_wr_data;
         end
         phase_ff        <= phase_in;
         type_held_ff    <= type_held_in;
         length_high_ff  <= length_high_in;
         payload_held_ff <= payload_held_in;
         bytes_left_ff   <= bytes_left_in;
         padding_held_ff <= padding_held_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.byte_kind    = rsp_item_ff.byte_kind;
   assign rsp_chan.byte_value   = rsp_item_ff.byte_value;
   assign rsp_chan.message_type = rsp_item_ff.message_type;
   assign rsp_chan.payload_size = rsp_item_ff.payload_size;
   assign rsp_chan.length_error = rsp_item_ff.length_error;
   assign rsp_chan.message_done = rsp_item_ff.message_done;

endmodule

>>> sv/thbp_checker.sv
module thbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_byte_kind,
   input logic [7:0]  rsp_byte_value,
   input logic        rsp_length_error,
   input logic        rsp_message_done
);
   import thbp_pkg::*;

   // A length error can only be reported on a length byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_length_error) |-> (rsp_byte_kind == KIND_LENGTH))
      else $error("length error on a byte that is not a length byte");

   // Completion is only flagged on a padding byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_message_done) |-> (rsp_byte_kind == KIND_PADDING))
      else $error("message done on a byte that is not padding");

   // Only the five defined kinds are ever reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_kind <= KIND_DISCARD))
      else $error("undefined byte kind");

   // No response is pending right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_byte_value)))
      else $error("stalled response changed");

endmodule

bind tls_heartbeat_message_parser_core thbp_checker u_thbp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_byte_kind    (rsp_chan.byte_kind),
   .rsp_byte_value   (rsp_chan.byte_value),
   .rsp_length_error (rsp_chan.length_error),
   .rsp_message_done (rsp_chan.message_done)
);

>>> test/tls_heartbeat_message_parser_core_tb.sv
module tls_heartbeat_message_parser_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import thbp_pkg::*;

   // A healthy run never goes this many cycles without a request or a response
   // moving. Gaps and stalls in this bench, and the path from a request to its
   // response, are all far shorter than that, so this leaves a wide margin.
   localparam int QUIET_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   thbp_req_if req_chan ();
   thbp_rsp_if rsp_chan ();

   tls_heartbeat_message_parser_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Our own copy of the parser state. It advances at the clock edge at which a
   // request is accepted, so it always describes the byte stream the block has seen.
   phase_type   parse_phase  = PH_TYPE;
   logic [7:0]  held_type    = '0;
   logic [7:0]  held_len_hi  = '0;
   logic [15:0] held_payload = '0;
   logic [15:0] held_left    = '0;
   logic [15:0] held_padding = '0;
   logic [15:0] record_len   = '0;

   // Classified bytes that are still owed by the block, oldest first.
   rsp_item_type classified_bytes[$];

   int  mismatch_count = 0;
   int  bytes_sent     = 0;
   int  quiet_cycles   = 0;
   bit  idle_on        = 1'b1;

   // Works out the response to one byte and moves the parser state on. A start
   // flag forces the byte to be read as a type byte, whatever came before.
   function automatic rsp_item_type classify_byte(logic [7:0] value, logic start);
      rsp_item_type r;
      int           nonpad;
      r.byte_kind    = KIND_DISCARD;
      r.byte_value   = value;
      r.length_error = 1'b0;
      r.message_done = 1'b0;
      if (start) begin
         parse_phase = PH_TYPE;
      end
      case (parse_phase)
         PH_TYPE: begin
            r.byte_kind  = KIND_TYPE;
            held_type    = value;
            held_payload = '0;
            parse_phase  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            r.byte_kind = KIND_LENGTH;
            held_len_hi = value;
            parse_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            // The length checks use the record length as it stands right now;
            // a later write does not touch the message in progress.
            r.byte_kind  = KIND_LENGTH;
            held_payload = {held_len_hi, value};
            nonpad       = int'(held_payload) + int'(HEADER_BYTES);
            if (nonpad > int'(record_len) ||
                int'(record_len) - nonpad < int'(MIN_PADDING) ||
                record_len > MAX_RECORD) begin
               r.length_error = 1'b1;
               parse_phase    = PH_DISCARD;
            end else begin
               held_padding = 16'(int'(record_len) - nonpad);
               // With no payload the parser goes straight on to the padding.
               if (held_payload != 0) begin
                  held_left   = held_payload;
                  parse_phase = PH_PAYLOAD;
               end else begin
                  held_left   = held_padding;
                  parse_phase = PH_PADDING;
               end
            end
         end
         PH_PAYLOAD: begin
            r.byte_kind = KIND_PAYLOAD;
            held_left   = held_left - 16'd1;
            if (held_left == 0) begin
               held_left   = held_padding;
               parse_phase = PH_PADDING;
            end
         end
         PH_PADDING: begin
            r.byte_kind = KIND_PADDING;
            held_left   = held_left - 16'd1;
            if (held_left == 0) begin
               r.message_done = 1'b1;
               parse_phase    = PH_DISCARD;
            end
         end
         default: begin
            // Everything after done or after a length error is thrown away
            // until the next start flag.
            r.byte_kind = KIND_DISCARD;
         end
      endcase
      r.message_type = held_type;
      r.payload_size = held_payload;
      return r;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Predicts each accepted request, then checks each accepted response against
   // the oldest prediction. Both happen at the rising edge, on pre-edge values.
   always @(posedge clock) begin : scoreboard
      rsp_item_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            classified_bytes.push_back(classify_byte(req_chan.data_byte, req_chan.start_flag));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (classified_bytes.size() == 0) begin
               $error("response with byte_value 'h%0h arrived with none expected",
                      rsp_chan.byte_value);
               mismatch_count++;
            end else begin
               want = classified_bytes.pop_front();
               check_field("byte_kind", 16'(want.byte_kind), 16'(rsp_chan.byte_kind));
               check_field("byte_value", 16'(want.byte_value), 16'(rsp_chan.byte_value));
               check_field("message_type", 16'(want.message_type),
                           16'(rsp_chan.message_type));
               check_field("payload_size", want.payload_size, rsp_chan.payload_size);
               check_field("length_error", 16'(want.length_error),
                           16'(rsp_chan.length_error));
               check_field("message_done", 16'(want.message_done),
                           16'(rsp_chan.message_done));
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tls_heartbeat_message_parser_core: mismatch");
            $finish;
         end
      end
   end

   // The response side stalls in random bursts while idling is allowed, and
   // otherwise keeps ready high so back-to-back responses are taken.
   initial begin
      rsp_chan.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
      end
   end

   // Sends one byte as a request and returns at the falling edge after it is
   // accepted, with valid lowered. A call that follows at once raises valid
   // again in the same step, so back-to-back requests leave no gap.
   task automatic push_byte(logic [7:0] value, logic start);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.data_byte  = value;
      req_chan.start_flag = start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      req_chan.valid = 1'b0;
      bytes_sent++;
   endtask

   // The record length may only change with nothing in flight, so this waits
   // until every classified byte has come back before writing it.
   task automatic write_record_length(logic [15:0] value);
      while (classified_bytes.size() != 0) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      record_len  = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // A record with no payload and exactly the minimum padding, then one stray
   // byte that must be discarded after done.
   task automatic test_zero_payload();
      write_record_length(16'd19);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      for (int i = 0; i < 16; i++) begin
         push_byte((i % 2 == 0) ? 8'h00 : 8'hFF, 1'b0);
      end
      push_byte(8'hA5, 1'b0);
   endtask

   // Length checks at their edges: the largest payload that still fits the
   // largest record, a record one byte over the limit, and an all-ones length
   // against an all-ones record.
   task automatic test_length_limits();
      write_record_length(MAX_RECORD);
      push_byte(8'h00, 1'b1);
      push_byte(8'h3F, 1'b0);
      push_byte(8'hED, 1'b0);
      write_record_length(MAX_RECORD + 16'd1);
      push_byte(8'h5A, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h33, 1'b0);
      write_record_length(16'hFFFF);
      push_byte(8'h02, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
   endtask

   // The record length is rewritten between the two length bytes, which must
   // take the new value, and again during the payload, which must change nothing.
   task automatic test_record_change();
      write_record_length(16'd19);
      push_byte(8'h01, 1'b1);
      push_byte(8'h00, 1'b0);
      write_record_length(16'd35);
      push_byte(8'h10, 1'b0);
      push_byte(8'hC3, 1'b0);
      write_record_length(16'd0);
      push_byte(8'h3C, 1'b0);
   endtask

   // One message against the current record length: mostly well formed with a
   // random payload length, sometimes with a length that cannot fit, sometimes
   // cut short by the next start flag, and sometimes plain noise.
   task automatic send_random_message();
      int          pick;
      int          body;
      int          room;
      logic [15:0] payload;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
         repeat ($urandom_range(1, 8)) begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end
      end else begin
         room = (record_len >= 19) ? int'(record_len) - 19 : 0;
         if (pick < 5) begin
            payload = 16'($urandom_range(0, 65535));
         end else begin
            payload = 16'($urandom_range(0, room));
         end
         push_byte(8'($urandom_range(0, 255)), 1'b1);
         push_byte(payload[15:8], 1'b0);
         if (pick == 5) begin
            write_record_length(16'($urandom_range(19, 64)));
         end
         push_byte(payload[7:0], 1'b0);
         // The prediction of the low length byte is already made, so the
         // parser copy tells how long the rest of this message is.
         if (parse_phase == PH_DISCARD) begin
            body = $urandom_range(0, 3);
         end else begin
            body = int'(held_payload) + int'(held_padding) + $urandom_range(0, 2);
         end
         if ($urandom_range(0, 9) == 0) begin
            body = $urandom_range(0, body);
         end
         repeat (body) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // Random records: mostly lengths that leave room for short messages, with
   // some longer records and some that every message must fail against.
   task automatic test_random_records();
      int          first;
      int          pick;
      logic [15:0] rec;
      first = bytes_sent;
      while (bytes_sent - first < 280) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            rec = 16'($urandom_range(19, 48));
         end else if (pick == 6) begin
            rec = 16'($urandom_range(49, 120));
         end else if (pick == 7) begin
            rec = 16'($urandom_range(0, 18));
         end else if (pick == 8) begin
            rec = 16'($urandom_range(16'h4001, 16'hFFFF));
         end else begin
            rec = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
         end
         write_record_length(rec);
         repeat ($urandom_range(2, 4)) send_random_message();
      end
   endtask

   // The last stretch runs with no gaps on either side, so the block has to
   // sustain one byte per cycle.
   task automatic test_full_rate();
      idle_on = 1'b0;
      write_record_length(16'($urandom_range(19, 40)));
      repeat (4) send_random_message();
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = '0;
      req_chan.start_flag = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_zero_payload();
      test_length_limits();
      test_record_change();
      test_random_records();
      test_full_rate();

      while (classified_bytes.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && classified_bytes.size() == 0) begin
         $display("tls_heartbeat_message_parser_core: match");
      end else begin
         $display("tls_heartbeat_message_parser_core: mismatch");
      end
      $finish;
   end

endmodule
